### rtl/pfgr_pkg.sv
// Package for the page framebuffer glyph renderer.
// Action codes, field widths and the controller/datapath command and status types.
package pfgr_pkg;

    localparam int ACTION_W = 3;
    localparam int COORD_W  = 16;
    localparam int CODE_W   = 8;
    localparam int FADDR_W  = 13;
    localparam int RADDR_W  = 10;
    localparam int PEN_W    = 16;
    localparam int HEIGHT_W = 7;

    localparam logic [2:0] ACT_CLEAR = 3'd0;
    localparam logic [2:0] ACT_FILL  = 3'd1;
    localparam logic [2:0] ACT_PIXEL = 3'd2;
    localparam logic [2:0] ACT_CHAR  = 3'd3;
    localparam logic [2:0] ACT_LOAD  = 3'd4;
    localparam logic [2:0] ACT_READ  = 3'd5;

    localparam logic [1:0] CFG_FIRST_CHAR   = 2'd0;
    localparam logic [1:0] CFG_CHAR_COUNT   = 2'd1;
    localparam logic [1:0] CFG_GLYPH_HEIGHT = 2'd2;

    localparam logic [7:0] FIRST_CHAR_RST   = 8'd32;
    localparam logic [7:0] CHAR_COUNT_RST   = 8'd224;
    localparam logic [6:0] GLYPH_HEIGHT_RST = 7'd24;

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b000000000001,
        ST_SWEEP  = 12'b000000000010,
        ST_RMW_RD = 12'b000000000100,
        ST_RMW_WR = 12'b000000001000,
        ST_READ   = 12'b000000010000,
        ST_WSUM_A = 12'b000000100000,
        ST_WSUM_D = 12'b000001000000,
        ST_FBYTE  = 12'b000010000000,
        ST_FDATA  = 12'b000100000000,
        ST_PIX    = 12'b001000000000,
        ST_RESULT = 12'b010000000000,
        ST_ROUT   = 12'b100000000000
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic latch;       // capture the item
        logic sweep_wr;    // write sweep byte at sweep count
        logic sweep_inc;
        logic pix_rd;      // read frame byte for pixel plot
        logic pix_wr;      // or-in pixel bit
        logic rd_frame;    // read frame byte at frame address
        logic font_wr;
        logic wsum_rd;     // read width i
        logic wsum_acc;    // add width term, i++
        logic wsum_done;   // width walk done (unused by the datapath)
        logic byte_rd;     // read next glyph byte
        logic byte_take;   // capture byte
        logic bit_step;    // advance bit/col/row
        logic pen_clear;
        logic pen_add;
        logic res_load;    // load result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] action;
        logic       sweep_last;
        logic       pix_on;     // pixel in range (for a glyph: and its bit set)
        logic       skip;       // code outside font
        logic       wsum_last;  // i == idx
        logic       rows_done;  // no more pixels
        logic       need_byte;  // bit == 0
        logic       string_start;
    } t_stat;

endpackage

### rtl/pfgr_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module pfgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/pfgr_ctrl.sv
// Controller state machine of the glyph renderer.
// Depends on pfgr_pkg.
module pfgr_ctrl
    import pfgr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    t_state r_state, n_state;
    logic   r_outv, n_outv;

    // sweep runs after reset as a clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP;
            r_outv  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_outv  <= n_outv;
        end
    end

    logic r_init;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_init <= 1'b1;
        else if (r_state == ST_SWEEP && i_stat.sweep_last) r_init <= 1'b0;
    end

    assign o_in_ready  = (r_state == ST_IDLE) && !r_outv;
    assign o_out_valid = r_outv;

    always_comb begin
        n_state = r_state;
        n_outv  = r_outv;
        o_cmd   = '0;
        if (r_outv && i_out_ready) n_outv = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && !r_outv) begin
                    o_cmd.latch = 1'b1;
                    n_state = ST_ROUT;
                end
            end
            ST_ROUT: begin
                case (i_stat.action)
                    ACT_CLEAR, ACT_FILL: n_state = ST_SWEEP;
                    ACT_PIXEL: n_state = i_stat.pix_on ? ST_RMW_RD : ST_RESULT;
                    ACT_CHAR: begin
                        if (i_stat.string_start) o_cmd.pen_clear = 1'b1;
                        n_state = i_stat.skip ? ST_RESULT : ST_WSUM_A;
                    end
                    ACT_LOAD: begin
                        o_cmd.font_wr = 1'b1;
                        n_state = ST_RESULT;
                    end
                    ACT_READ: begin
                        o_cmd.rd_frame = 1'b1;
                        n_state = ST_READ;
                    end
                    default: n_state = ST_RESULT;
                endcase
            end
            ST_SWEEP: begin
                o_cmd.sweep_wr  = 1'b1;
                o_cmd.sweep_inc = 1'b1;
                if (i_stat.sweep_last) n_state = r_init ? ST_IDLE : ST_RESULT;
            end
            ST_RMW_RD: begin
                o_cmd.pix_rd = 1'b1;
                n_state = ST_RMW_WR;
            end
            ST_RMW_WR: begin
                o_cmd.pix_wr = 1'b1;
                if (i_stat.action == ACT_PIXEL) n_state = ST_RESULT;
                else begin
                    o_cmd.bit_step = 1'b1;
                    n_state = ST_FDATA;
                end
            end
            ST_READ: n_state = ST_RESULT;
            ST_WSUM_A: begin
                o_cmd.wsum_rd = 1'b1;
                n_state = ST_WSUM_D;
            end
            ST_WSUM_D: begin
                if (i_stat.wsum_last) begin
                    o_cmd.wsum_done = 1'b1;
                    n_state = ST_FDATA;
                end else begin
                    o_cmd.wsum_acc = 1'b1;
                    n_state = ST_WSUM_A;
                end
            end
            ST_FDATA: begin
                if (i_stat.rows_done) begin
                    o_cmd.pen_add = 1'b1;
                    n_state = ST_RESULT;
                end else if (i_stat.need_byte) begin
                    o_cmd.byte_rd = 1'b1;
                    n_state = ST_FBYTE;
                end else n_state = ST_PIX;
            end
            ST_FBYTE: begin
                o_cmd.byte_take = 1'b1;
                n_state = ST_PIX;
            end
            ST_PIX: begin
                if (i_stat.pix_on) begin
                    o_cmd.pix_rd = 1'b1;
                    n_state = ST_RMW_WR;
                end else begin
                    o_cmd.bit_step = 1'b1;
                    n_state = ST_FDATA;
                end
            end
            ST_RESULT: begin
                if (!r_outv || i_out_ready) begin
                    o_cmd.res_load = 1'b1;
                    n_outv  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

### rtl/pfgr_dp.sv
// Datapath of the glyph renderer: frame and font memories, glyph walk, pen.
// Depends on pfgr_pkg and pfgr_ram.
module pfgr_dp
    import pfgr_pkg::*;
#(
    parameter int DISPLAY_WIDTH  = 128,
    parameter int DISPLAY_HEIGHT = 64,
    parameter int FONT_BYTES     = 8192,
    parameter int WIDTHS_OFFSET  = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [ACTION_W-1:0]  i_action,
    input  logic [COORD_W-1:0]   i_x_pos,
    input  logic [COORD_W-1:0]   i_y_pos,
    input  logic [CODE_W-1:0]    i_char_code,
    input  logic                 i_string_start,
    input  logic [FADDR_W-1:0]   i_font_address,
    input  logic [7:0]           i_font_byte,
    input  logic [RADDR_W-1:0]   i_frame_address,
    input  logic [7:0]           i_first_char,
    input  logic [7:0]           i_char_count,
    input  logic [HEIGHT_W-1:0]  i_glyph_height,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    output logic [7:0]           o_read_data,
    output logic [PEN_W-1:0]     o_pen_offset,
    output logic                 o_char_skipped
);
    localparam int PAGES       = (DISPLAY_HEIGHT + 7) / 8;
    localparam int FRAME_BYTES = DISPLAY_WIDTH * PAGES;
    localparam int FRAW        = $clog2(FRAME_BYTES);
    localparam int FOAW        = $clog2(FONT_BYTES);
    localparam int CW          = $clog2(DISPLAY_WIDTH);
    // address accumulator wide enough for 255 glyphs of 255*127/8+1 bytes
    localparam int AW          = 24;

    logic [ACTION_W-1:0]       r_action;
    logic signed [COORD_W:0]   r_x, r_y;
    logic [CODE_W-1:0]         r_code;
    logic                      r_start;
    logic [FADDR_W-1:0]        r_faddr;
    logic [7:0]                r_fbyte;
    logic [RADDR_W-1:0]        r_raddr;
    logic [FRAW:0]             r_sweep;
    logic [PEN_W-1:0]          r_pen;
    logic [7:0]                r_i, r_w;
    logic [AW-1:0]             r_addr;
    logic [2:0]                r_bit;
    logic [7:0]                r_byte, r_col;
    logic [HEIGHT_W-1:0]       r_row;
    logic                      r_init;
    logic [7:0]                r_rd, r_pbit;
    logic [FRAW-1:0]           r_paddr;
    logic [7:0]                r_res_rd;
    logic                      r_res_skip;
    logic                      r_i_fetch;
    logic                      r_wsum_ok, r_byte_ok;

    // pixel coordinate (19-bit signed) with pen added for glyphs
    logic signed [COORD_W+2:0] px, py;
    logic                      on;
    logic [FRAW-1:0]           fidx;
    logic [8:0]                idx;
    logic                      skip;

    logic [FRAW-1:0] fr_addr;
    logic            fr_we;
    logic [7:0]      fr_wdata, fr_rdata;
    logic [FOAW-1:0] fo_addr;
    logic            fo_we;
    logic [7:0]      fo_rdata;
    logic [7:0]      wcur;
    logic [AW-1:0]   term;
    logic [15:0]     prod;
    logic [AW-1:0]   waddr;

    always_comb begin
        if (r_action == ACT_CHAR) begin
            px = (COORD_W+3)'(r_x) + $signed({3'b000, r_pen}) + $signed({11'd0, r_col});
            py = (COORD_W+3)'(r_y) + $signed({12'd0, r_row});
        end else begin
            px = (COORD_W+3)'(r_x);
            py = (COORD_W+3)'(r_y);
        end
        on = (px >= 0) && (px < DISPLAY_WIDTH) && (py >= 0) && (py < DISPLAY_HEIGHT);
        fidx = FRAW'((py >>> 3) * DISPLAY_WIDTH + px);
        if (r_action == ACT_CHAR) on = on && r_byte[r_bit];
        idx  = {1'b0, r_code} - {1'b0, i_first_char};
        skip = idx[8] || (idx[7:0] >= i_char_count);
    end

    // width byte of the current table read, valid in the cycle after wsum_rd
    assign wcur  = r_wsum_ok ? fo_rdata : 8'h00;
    assign prod  = 16'(wcur) * 16'(i_glyph_height);
    assign term  = AW'(prod >> 3) + AW'(1);
    assign waddr = AW'(WIDTHS_OFFSET) + AW'(r_i);

    always_comb begin
        fr_we    = 1'b0;
        fr_wdata = r_pbit;
        fr_addr  = fidx;
        if (i_cmd.sweep_wr) begin
            fr_we    = 1'b1;
            fr_addr  = r_sweep[FRAW-1:0];
            fr_wdata = (!r_init && r_action == ACT_FILL) ? 8'hFF : 8'h00;
        end else if (i_cmd.pix_wr) begin
            fr_we    = 1'b1;
            fr_addr  = r_paddr;
            fr_wdata = fr_rdata | r_pbit;
        end else if (i_cmd.rd_frame || r_action == ACT_READ) begin
            fr_addr  = FRAW'(r_raddr);
        end
    end

    always_comb begin
        fo_we   = i_cmd.font_wr && (32'(r_faddr) < FONT_BYTES);
        fo_addr = FOAW'(r_faddr);
        if (i_cmd.wsum_rd) fo_addr = FOAW'(waddr);
        else if (i_cmd.byte_rd) fo_addr = FOAW'(r_addr);
    end

    pfgr_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame (
        .i_clk(i_clk), .i_we(fr_we), .i_addr(fr_addr),
        .i_wdata(fr_wdata), .o_rdata(fr_rdata)
    );
    pfgr_ram #(.WIDTH(8), .DEPTH(FONT_BYTES)) u_font (
        .i_clk(i_clk), .i_we(fo_we), .i_addr(fo_addr),
        .i_wdata(r_fbyte), .o_rdata(fo_rdata)
    );

    always_ff @(posedge i_clk) begin
        r_wsum_ok <= 32'(waddr) < FONT_BYTES;
        r_byte_ok <= 32'(r_addr) < FONT_BYTES;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen   <= '0;
            r_sweep <= '0;
            r_init  <= 1'b1;
        end else begin
            if (i_cmd.sweep_inc) begin
                if (r_sweep == (FRAW+1)'(FRAME_BYTES - 1)) begin
                    r_sweep <= '0;
                    r_init  <= 1'b0;
                end else r_sweep <= r_sweep + 1'b1;
            end
            if (i_cmd.pen_clear) r_pen <= '0;
            else if (i_cmd.pen_add) begin
                if (17'(r_pen) + 17'(r_w) > 17'hFFFF) r_pen <= 16'hFFFF;
                else r_pen <= r_pen + 16'(r_w);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_action <= i_action;
            r_x      <= (COORD_W+1)'($signed(i_x_pos));
            r_y      <= (COORD_W+1)'($signed(i_y_pos));
            r_code   <= i_char_code;
            r_start  <= i_string_start;
            r_faddr  <= i_font_address;
            r_fbyte  <= i_font_byte;
            r_raddr  <= i_frame_address;
            r_i      <= '0;
            r_addr   <= AW'(WIDTHS_OFFSET) + AW'(i_char_count);
            r_col    <= '0;
            r_row    <= '0;
            r_bit    <= '0;
        end
        if (i_cmd.pix_rd || (r_action == ACT_PIXEL && !i_cmd.pix_wr)) begin
            r_paddr <= fidx;
            r_pbit  <= 8'h01 << py[2:0];
        end
        if (i_cmd.wsum_acc) begin
            r_addr <= r_addr + term;
            r_i    <= r_i + 1'b1;
        end
        // r_w doubles as width read staging
        if (r_i_fetch) r_w <= wcur;
        if (i_cmd.byte_rd) r_addr <= r_addr + 1'b1;
        if (i_cmd.byte_take) r_byte <= r_byte_ok ? fo_rdata : 8'h00;
        if (i_cmd.bit_step) begin
            r_bit <= r_bit + 1'b1;
            if (r_col + 1'b1 >= r_w) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
            end else r_col <= r_col + 1'b1;
        end
        if (i_cmd.rd_frame) r_rd <= (32'(r_raddr) < FRAME_BYTES) ? 8'h01 : 8'h00;
        if (i_cmd.res_load) begin
            r_res_rd   <= (r_action == ACT_READ && r_rd[0]) ? fr_rdata : 8'h00;
            r_res_skip <= (r_action == ACT_CHAR) && skip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_i_fetch <= 1'b0;
        else r_i_fetch <= i_cmd.wsum_rd;
    end

    assign o_stat.action       = r_action;
    assign o_stat.sweep_last   = (r_sweep == (FRAW+1)'(FRAME_BYTES - 1));
    assign o_stat.pix_on       = on;
    assign o_stat.skip         = skip;
    assign o_stat.wsum_last    = (r_i == idx[7:0]);
    assign o_stat.rows_done    = (r_row >= i_glyph_height) || (r_w == 8'd0);
    assign o_stat.need_byte    = (r_bit == 3'd0);
    assign o_stat.string_start = r_start;

    assign o_read_data    = r_res_rd;
    assign o_pen_offset   = r_pen;
    assign o_char_skipped = r_res_skip;
endmodule

### rtl/page_framebuffer_glyph_renderer_top.sv
// Top level of the page framebuffer glyph renderer.
// Depends on pfgr_pkg, pfgr_ctrl, pfgr_dp, pfgr_ram.
//
// One item at a time. Load and unknown actions go from decode to the result; a
// read adds a frame read, and set pixel a read-modify-write of the frame byte
// when the pixel is in range; clear and fill sweep the frame memory one byte a
// cycle (DISPLAY_WIDTH*pages, 1024 by default); a character first walks the
// width table for every glyph up to and including its own (over the single font
// port), then visits each glyph pixel, with a frame read-modify-write for a set
// one and a font read per glyph byte. After reset the frame memory is swept to zero before the first item is taken.
module page_framebuffer_glyph_renderer_top
    import pfgr_pkg::*;
#(
    parameter int DISPLAY_WIDTH  = 128,
    parameter int DISPLAY_HEIGHT = 64,
    parameter int FONT_BYTES     = 8192,
    parameter int WIDTHS_OFFSET  = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[2:0] x_pos[18:3] y_pos[34:19] char_code[42:35] string_start[43]
    // font_address[56:44] font_byte[64:57] frame_address[74:65]
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[7:0] pen_offset[23:8] char_skipped[24]
    output logic [31:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    logic [7:0] r_first_char, r_char_count;
    logic [6:0] r_glyph_height;
    t_cmd  cmd;
    t_stat stat;
    logic [7:0]  rd;
    logic [15:0] pen;
    logic        skipped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_char   <= FIRST_CHAR_RST;
            r_char_count   <= CHAR_COUNT_RST;
            r_glyph_height <= GLYPH_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FIRST_CHAR:   r_first_char   <= i_cfg_data;
                CFG_CHAR_COUNT:   r_char_count   <= i_cfg_data;
                CFG_GLYPH_HEIGHT: r_glyph_height <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    pfgr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_stat(stat), .o_cmd(cmd)
    );

    pfgr_dp #(
        .DISPLAY_WIDTH(DISPLAY_WIDTH), .DISPLAY_HEIGHT(DISPLAY_HEIGHT),
        .FONT_BYTES(FONT_BYTES), .WIDTHS_OFFSET(WIDTHS_OFFSET)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_action(s_axis_tdata[2:0]),
        .i_x_pos(s_axis_tdata[18:3]),
        .i_y_pos(s_axis_tdata[34:19]),
        .i_char_code(s_axis_tdata[42:35]),
        .i_string_start(s_axis_tdata[43]),
        .i_font_address(s_axis_tdata[56:44]),
        .i_font_byte(s_axis_tdata[64:57]),
        .i_frame_address(s_axis_tdata[74:65]),
        .i_first_char(r_first_char), .i_char_count(r_char_count),
        .i_glyph_height(r_glyph_height),
        .i_cmd(cmd), .o_stat(stat),
        .o_read_data(rd), .o_pen_offset(pen), .o_char_skipped(skipped)
    );

    assign m_axis_tdata = {7'd0, skipped, pen, rd};
endmodule

### bench/page_framebuffer_glyph_renderer_checker.sv
// Checker for the page framebuffer glyph renderer: watches the input, output and
// configuration ports, predicts every result and compares it field by field.
// Depends on pfgr_pkg.
module page_framebuffer_glyph_renderer_checker
    import pfgr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [79:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int DISP_W     = 128;
    localparam int DISP_H     = 64;
    localparam int FRAME_SIZE = DISP_W * ((DISP_H + 7) / 8);
    localparam int FONT_SIZE  = 8192;
    localparam int WIDTH_BASE = 4;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [15:0] pen_offset;
        logic        char_skipped;
    } result_t;

    logic [7:0]  frame_img [FRAME_SIZE];
    logic [7:0]  font_img  [FONT_SIZE];
    logic [16:0] pen;
    logic [7:0]  first_code;
    logic [7:0]  glyph_total;
    logic [6:0]  rows;
    result_t     expected_q [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        pen          = '0;
        first_code   = FIRST_CHAR_RST;
        glyph_total  = CHAR_COUNT_RST;
        rows         = GLYPH_HEIGHT_RST;
        foreach (frame_img[i]) frame_img[i] = '0;
        foreach (font_img[i]) font_img[i] = '0;
    end

    function automatic int font_byte_at(int addr);
        return (addr < FONT_SIZE) ? int'(font_img[addr]) : 0;
    endfunction

    function automatic void plot(int x, int y);
        if (x >= 0 && x < DISP_W && y >= 0 && y < DISP_H)
            frame_img[(y / 8) * DISP_W + x] |= 8'(1 << (y % 8));
    endfunction

    function automatic logic render_char(int x, int y, int code);
        int idx, addr, w, glyph_bits, bitn, pen_now;
        idx = code - int'(first_code);
        if (code < int'(first_code) || idx >= int'(glyph_total))
            return 1'b1;
        addr = WIDTH_BASE + int'(glyph_total);
        for (int i = 0; i < idx; i++)
            addr += font_byte_at(WIDTH_BASE + i) * int'(rows) / 8 + 1;
        w = font_byte_at(WIDTH_BASE + idx);
        bitn = 0;
        glyph_bits = 0;
        pen_now = int'(pen);
        for (int r = 0; r < int'(rows); r++) begin
            for (int c = 0; c < w; c++) begin
                if (bitn == 0) begin
                    glyph_bits = font_byte_at(addr);
                    addr++;
                end
                if (glyph_bits[bitn])
                    plot(x + pen_now + c, y + r);
                bitn = (bitn + 1) % 8;
            end
        end
        pen = (pen + 17'(w) > 17'hFFFF) ? 17'hFFFF : pen + 17'(w);
        return 1'b0;
    endfunction

    function automatic result_t predict(logic [79:0] d);
        result_t res;
        logic [2:0] act;
        act = d[2:0];
        res = '0;
        case (act)
            ACT_CLEAR: foreach (frame_img[i]) frame_img[i] = 8'h00;
            ACT_FILL:  foreach (frame_img[i]) frame_img[i] = 8'hFF;
            ACT_PIXEL: plot(int'($signed(d[18:3])), int'($signed(d[34:19])));
            ACT_CHAR: begin
                if (d[43])
                    pen = '0;
                res.char_skipped = render_char(int'($signed(d[18:3])),
                                               int'($signed(d[34:19])), int'(d[42:35]));
            end
            ACT_LOAD:  font_img[d[56:44]] = d[64:57];
            ACT_READ:  res.read_data = frame_img[d[74:65]];
            default: ;
        endcase
        res.pen_offset = pen[15:0];
        return res;
    endfunction

    task automatic compare_result(logic [31:0] d);
        result_t exp_r;
        if (expected_q.size() == 0) begin
            $error("unexpected result transfer: %h", d);
            o_fail_count++;
            return;
        end
        exp_r = expected_q.pop_front();
        if (d[7:0] !== exp_r.read_data) begin
            $error("read_data: expected %0d, actual %0d", exp_r.read_data, d[7:0]);
            o_fail_count++;
        end
        if (d[23:8] !== exp_r.pen_offset) begin
            $error("pen_offset: expected %0d, actual %0d", exp_r.pen_offset, d[23:8]);
            o_fail_count++;
        end
        if (d[24] !== exp_r.char_skipped) begin
            $error("char_skipped: expected %0d, actual %0d", exp_r.char_skipped, d[24]);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FIRST_CHAR:   first_code  = i_cfg_data;
                    CFG_CHAR_COUNT:   glyph_total = i_cfg_data;
                    CFG_GLYPH_HEIGHT: rows        = i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready)
                compare_result(i_m_tdata);
            if (i_s_tvalid && i_s_tready)
                expected_q.push_back(predict(i_s_tdata));
            o_pending = expected_q.size();
        end
    end

endmodule

### bench/page_framebuffer_glyph_renderer_top_test.sv
// Testbench top for the page framebuffer glyph renderer: clock, reset, stimulus,
// random stalls on both streams and the final verdict.
// Depends on pfgr_pkg, page_framebuffer_glyph_renderer_top and the checker module.
module page_framebuffer_glyph_renderer_top_test;
    import pfgr_pkg::*;

    localparam logic [2:0] ACT_SPARE_A = 3'd6;
    localparam logic [2:0] ACT_SPARE_B = 3'd7;
    localparam int WIDTH_BASE  = 4;
    localparam int FONT_SIZE   = 8192;
    localparam int CYCLE_LIMIT = 6000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;
    int          fail_count;
    int          pending;
    int          cycles;
    bit          hold_req;

    // font contents as loaded, to keep draws on written entries only
    logic [7:0]  font_copy [FONT_SIZE];
    bit          font_valid [FONT_SIZE];
    int          first_code;
    int          glyph_total;
    int          rows;
    // widths above this are reloaded small before a draw
    int          max_width;

    page_framebuffer_glyph_renderer_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    page_framebuffer_glyph_renderer_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("page_framebuffer_glyph_renderer_top regression: fail");
            $finish;
        end
    end

    // receiver: random runs and stalls, plus one long hold-off on request
    initial begin
        int run_left, stall_left;
        run_left = 0;
        stall_left = 0;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                stall_left = 800;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
                m_axis_tready <= 1'b1;
            end else begin
                run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                                       : $urandom_range(0, 6);
                case ($urandom_range(0, 19))
                    0, 1:    stall_left = $urandom_range(15, 80);
                    2, 3, 4: stall_left = 0;
                    default: stall_left = $urandom_range(1, 3);
                endcase
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(logic [2:0] act, logic [15:0] x, logic [15:0] y,
                             logic [7:0] code, logic start, logic [12:0] fa,
                             logic [7:0] fb, logic [9:0] ra);
        int gap;
        case ($urandom_range(0, 19))
            0:          gap = $urandom_range(10, 60);
            1, 2, 3, 4,
            5, 6, 7:    gap = $urandom_range(1, 3);
            default:    gap = 0;
        endcase
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, ra, fb, fa, start, code, y, x, act};
        do @(posedge i_clk); while (!s_axis_tready);
        if (act == ACT_LOAD) begin
            font_copy[fa]  = fb;
            font_valid[fa] = 1'b1;
        end
    endtask

    task automatic send_load(int addr, logic [7:0] value);
        send_item(ACT_LOAD, 16'($urandom), 16'($urandom), 8'($urandom), 1'($urandom),
                  13'(addr), value, 10'($urandom));
    endtask

    task automatic send_simple(logic [2:0] act, logic [15:0] x, logic [15:0] y,
                               logic [9:0] ra);
        send_item(act, x, y, 8'($urandom), 1'($urandom), 13'($urandom),
                  8'($urandom), ra);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= 8'(value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_FIRST_CHAR:   first_code  = value;
            CFG_CHAR_COUNT:   glyph_total = value;
            CFG_GLYPH_HEIGHT: rows        = value;
            default: ;
        endcase
    endtask

    task automatic set_font_format(int fc, int cc, int h);
        write_reg(CFG_FIRST_CHAR, fc);
        write_reg(CFG_CHAR_COUNT, cc);
        write_reg(CFG_GLYPH_HEIGHT, h);
    endtask

    // load every font byte the glyph will read that was never written, and reload widths above max_width
    task automatic prepare_glyph(int code);
        int idx, base, nbytes;
        idx = code - first_code;
        if (code < first_code || idx >= glyph_total)
            return;
        for (int i = 0; i <= idx; i++)
            if (!font_valid[WIDTH_BASE + i] ||
                int'(font_copy[WIDTH_BASE + i]) > max_width)
                send_load(WIDTH_BASE + i, 8'($urandom_range(0, 8)));
        base = WIDTH_BASE + glyph_total;
        for (int i = 0; i < idx; i++)
            base += int'(font_copy[WIDTH_BASE + i]) * rows / 8 + 1;
        nbytes = (int'(font_copy[WIDTH_BASE + idx]) * rows + 7) / 8;
        for (int a = base; a < base + nbytes && a < FONT_SIZE; a++)
            if (!font_valid[a])
                send_load(a, 8'($urandom));
    endtask

    task automatic draw(int code, logic start, logic [15:0] x, logic [15:0] y);
        prepare_glyph(code);
        send_item(ACT_CHAR, x, y, 8'(code), start, 13'($urandom), 8'($urandom),
                  10'($urandom));
    endtask

    task automatic random_phase(int count);
        int sel, code, span;
        logic [15:0] x, y;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if ($urandom_range(0, 4) == 0) begin
                x = 16'($urandom);
                y = 16'($urandom);
            end else begin
                x = 16'($urandom_range(0, 150) - 12);
                y = 16'($urandom_range(0, 84) - 12);
            end
            if (sel < 40) begin
                span = (glyph_total < 10) ? glyph_total + 1 : 10;
                code = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                   : first_code + $urandom_range(0, span);
                if (code > 255)
                    code = 255;
                draw(code, ($urandom_range(0, 2) != 0), x, y);
            end else if (sel < 62) begin
                send_simple(ACT_PIXEL, x, y, 10'($urandom));
            end else if (sel < 84) begin
                send_simple(ACT_READ, x, y, 10'($urandom));
            end else if (sel < 93) begin
                send_load($urandom_range(512, FONT_SIZE - 1), 8'($urandom));
            end else if (sel < 95) begin
                send_simple(ACT_CLEAR, x, y, 10'($urandom));
            end else if (sel < 97) begin
                send_simple(ACT_FILL, x, y, 10'($urandom));
            end else begin
                send_simple(($urandom_range(0, 1) != 0) ? ACT_SPARE_A : ACT_SPARE_B,
                            x, y, 10'($urandom));
            end
        end
    endtask

    initial begin
        cycles        = 0;
        hold_req      = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_FIRST_CHAR;
        i_cfg_data    = '0;
        first_code    = FIRST_CHAR_RST;
        glyph_total   = CHAR_COUNT_RST;
        rows          = GLYPH_HEIGHT_RST;
        max_width     = 8;
        foreach (font_valid[i]) font_valid[i] = 1'b0;
        foreach (font_copy[i]) font_copy[i] = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed
        set_font_format(65, 4, 8);
        send_simple(ACT_READ, 0, 0, 10'd0);
        send_simple(ACT_FILL, 0, 0, 10'd0);
        send_simple(ACT_READ, 0, 0, 10'd1023);
        send_simple(ACT_CLEAR, 0, 0, 10'd0);
        send_simple(ACT_READ, 0, 0, 10'd1023);
        send_simple(ACT_PIXEL, 16'd0, 16'd0, 10'd0);
        send_simple(ACT_PIXEL, 16'd127, 16'd63, 10'd0);
        send_simple(ACT_PIXEL, 16'd128, 16'd0, 10'd0);
        send_simple(ACT_PIXEL, 16'hFFFF, 16'd5, 10'd0);
        send_simple(ACT_PIXEL, 16'h8000, 16'h7FFF, 10'd0);
        send_simple(ACT_PIXEL, 16'h7FFF, 16'h8000, 10'd0);
        send_simple(ACT_READ, 0, 0, 10'd0);
        send_simple(ACT_READ, 0, 0, 10'd1023);
        draw(64, 1'b1, 16'd0, 16'd0);
        draw(69, 1'b1, 16'd0, 16'd0);
        draw(65, 1'b1, 16'd0, 16'd0);
        draw(66, 1'b0, 16'd0, 16'd0);
        draw(68, 1'b0, 16'hFFFC, 16'hFFFC);
        draw(68, 1'b1, 16'h8000, 16'h7FFF);
        send_simple(ACT_SPARE_A, 16'hFFFF, 16'hFFFF, 10'h3FF);
        send_simple(ACT_SPARE_B, 0, 0, 10'd0);
        send_simple(ACT_READ, 0, 0, 10'd1);

        // pen saturation with one very wide, one-row glyph
        set_font_format(0, 1, 1);
        max_width = 255;
        send_load(WIDTH_BASE, 8'd255);
        draw(0, 1'b1, 16'd0, 16'd10);
        for (int n = 0; n < 258; n++)
            draw(0, 1'b0, 16'h8000, 16'd10);
        draw(1, 1'b0, 16'd0, 16'd0);
        draw(0, 1'b1, 16'd0, 16'd20);
        send_load(WIDTH_BASE, 8'd3);
        max_width = 8;

        // random, with long receiver hold-off at the start
        set_font_format(32, 96, 16);
        hold_req = 1'b1;
        random_phase(40);
        wait_idle();
        set_font_format(255, 255, 64);
        random_phase(15);
        set_font_format(0, 0, 1);
        random_phase(15);
        set_font_format(0, 255, 12);
        random_phase(30);
        set_font_format($urandom_range(0, 200), $urandom_range(1, 40),
                        $urandom_range(1, 24));
        random_phase(30);
        set_font_format($urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(1, 64));
        random_phase(20);

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("page_framebuffer_glyph_renderer_top regression: pass");
        else
            $display("page_framebuffer_glyph_renderer_top regression: fail");
        $finish;
    end

endmodule
